// ===== rtl/swas_pkg.sv =====
// shared constants, types and codes of the sliding window anagram search
// no dependencies; used by sliding_window_anagram_search
package swas_pkg;

  // longest pattern that is stored; also the depth of the text history ring
  localparam int unsigned PATTERN_MAX = 1024;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned NUM_SYMS    = 1 << SYM_W;
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CNT_W       = LEN_W;
  localparam int unsigned OLD_W       = LEN_W + 1;
  localparam int unsigned HIST_AW     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned DIST_W      = $clog2(NUM_SYMS + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_AW      = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW      = $clog2(OUT_DEPTH + 1);

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [OLD_W-1:0]   oldsum_t;
  typedef logic [HIST_AW-1:0] haddr_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [OUT_AW-1:0]  optr_t;
  typedef logic [OUT_CW-1:0]  ocnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_FIRST = 2'd0,
    OP_MORE  = 2'd1,
    OP_TEXT  = 2'd2
  } opcode_e;

  // what an item does once it is classified at the input
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PAT,
    KIND_TEXT,
    KIND_EMPTY
  } kind_e;

  // count table word: pattern count and number of text bytes added so far
  typedef struct packed {
    count_t pat;
    count_t seen;
  } cnt_t;

  // history word: text byte and its occurrence number for that byte value
  typedef struct packed {
    sym_t   sym;
    count_t occ;
  } hist_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic done_res;
    logic length_error;
  } res_t;

endpackage

// ===== rtl/sliding_window_anagram_search.sv =====
// a result passes the stage 1 registers, the stage 2 registers and the result queue before it is shown
// throughput: one byte per cycle while the result queue has room for every item in flight;
//   the count table read-modify-write is forwarded across the two pipeline stages, a
//   four-entry result queue absorbs output stalls
// reset: clears control state and the table valid bits; no clearing pass,
//   a first pattern byte clears the count tables at once through valid bits
// sliding window anagram search: count tables, history ring, result queue
// depends on swas_pkg
module sliding_window_anagram_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0] s_axis_tuser,   // [1:0] opcode
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] window_match, [1] found, [2] length_error
  output logic       m_axis_tlast    // done_res
);

  // memories
  swas_pkg::cnt_t   cnt_mem  [swas_pkg::NUM_SYMS];
  swas_pkg::count_t rem_mem  [swas_pkg::NUM_SYMS];
  swas_pkg::hist_t  hist_mem [swas_pkg::PATTERN_MAX];

  logic [swas_pkg::NUM_SYMS-1:0] vld_a_q, vld_a_d;
  logic [swas_pkg::NUM_SYMS-1:0] vld_r_q, vld_r_d;

  // front state
  swas_pkg::len_t   len_q, len_d;
  swas_pkg::len_t   seen_q, seen_d;
  swas_pkg::haddr_t hp_q, hp_d;
  logic             ovf_q, ovf_d;

  logic              accept;
  swas_pkg::opcode_e op;
  swas_pkg::kind_e   kind;
  logic              clr;
  logic              full;
  swas_pkg::oldsum_t old_sum;
  swas_pkg::haddr_t  old_addr;

  // stage 1 registers
  logic              p1_valid_q;
  swas_pkg::kind_e   p1_kind_q;
  logic              p1_clr_q;
  logic              p1_full_q;
  logic              p1_last_q;
  logic              p1_ovf_q;
  logic              p1_self_q;
  swas_pkg::sym_t    p1_sym_q;
  swas_pkg::haddr_t  p1_hp_q;
  swas_pkg::haddr_t  p1_old_q;
  swas_pkg::cnt_t    a_rdb_q;
  swas_pkg::count_t  r_rdb_q;
  swas_pkg::hist_t   h_rd_q;

  // stage 1 logic
  swas_pkg::cnt_t   cnt_b;
  swas_pkg::count_t rem_b;
  swas_pkg::count_t seen_new;
  swas_pkg::count_t wc_b;
  swas_pkg::hist_t  hist_new;
  swas_pkg::hist_t  hist_d;
  logic             inc_sat;
  logic             a_we, h_we, r_we;
  swas_pkg::cnt_t   a_wdata;
  swas_pkg::dist_t  dn_q, dn_d;

  // stage 2 registers, including the writes done by this item in stage 1
  logic              p2_valid_q;
  swas_pkg::kind_e   p2_kind_q;
  logic              p2_clr_q;
  logic              p2_full_q;
  logic              p2_last_q;
  logic              p2_ovf_q;
  logic              p2_inc_q;
  swas_pkg::sym_t    p2_dsym_q;
  swas_pkg::count_t  p2_occ_q;
  logic              p2_awe_q, p2_rwe_q, p2_hwe_q;
  swas_pkg::sym_t    p2_asym_q, p2_rsym_q;
  swas_pkg::cnt_t    p2_adata_q;
  swas_pkg::count_t  p2_rdata_q;
  swas_pkg::haddr_t  p2_hp_q;
  swas_pkg::hist_t   p2_hdata_q;
  swas_pkg::cnt_t    a_rdd_q;

  // stage 2 logic
  swas_pkg::cnt_t   cnt_d;
  swas_pkg::count_t wc_d;
  logic             dec_sat;
  swas_pkg::dist_t  sat_q, sat_d;
  swas_pkg::dist_t  sat_inc;
  logic             found_q, found_d;
  swas_pkg::res_t   res;

  // result queue
  swas_pkg::res_t  out_q [swas_pkg::OUT_DEPTH];
  swas_pkg::optr_t wr_ptr_q, rd_ptr_q;
  swas_pkg::ocnt_t fifo_cnt_q;
  logic            push, pop;
  swas_pkg::res_t  out_res;

  // input handshake: room for every item in flight
  assign s_axis_tready = (fifo_cnt_q + swas_pkg::ocnt_t'(p1_valid_q)
                          + swas_pkg::ocnt_t'(p2_valid_q))
                         < swas_pkg::ocnt_t'(swas_pkg::OUT_DEPTH);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign op     = swas_pkg::opcode_e'(s_axis_tuser);

  // ring slot of the byte that leaves the window
  always_comb begin
    old_sum = swas_pkg::oldsum_t'(hp_q) + swas_pkg::oldsum_t'(swas_pkg::PATTERN_MAX)
              + swas_pkg::oldsum_t'(1) - swas_pkg::oldsum_t'(len_q);
    if (old_sum >= swas_pkg::oldsum_t'(swas_pkg::PATTERN_MAX)) begin
      old_sum = old_sum - swas_pkg::oldsum_t'(swas_pkg::PATTERN_MAX);
    end
    if (len_q == '0) begin
      old_addr = '0;
    end else begin
      old_addr = old_sum[swas_pkg::HIST_AW-1:0];
    end
  end

  // classify the item and update the job counters
  always_comb begin
    len_d  = len_q;
    seen_d = seen_q;
    hp_d   = hp_q;
    ovf_d  = ovf_q;
    kind   = swas_pkg::KIND_NONE;
    clr    = 1'b0;
    full   = (swas_pkg::oldsum_t'(seen_q) + swas_pkg::oldsum_t'(1))
             >= swas_pkg::oldsum_t'(len_q);
    if (accept) begin
      unique case (op)
        swas_pkg::OP_FIRST: begin
          clr    = 1'b1;
          kind   = swas_pkg::KIND_PAT;
          len_d  = swas_pkg::len_t'(1);
          seen_d = '0;
          hp_d   = '0;
          ovf_d  = 1'b0;
        end
        swas_pkg::OP_MORE: begin
          if (seen_q == '0) begin
            if (len_q >= swas_pkg::len_t'(swas_pkg::PATTERN_MAX)) begin
              ovf_d = 1'b1;
            end else begin
              kind  = swas_pkg::KIND_PAT;
              len_d = len_q + swas_pkg::len_t'(1);
            end
          end
        end
        swas_pkg::OP_TEXT: begin
          if (len_q == '0) begin
            kind = swas_pkg::KIND_EMPTY;
          end else begin
            kind = swas_pkg::KIND_TEXT;
            if (hp_q == swas_pkg::haddr_t'(swas_pkg::PATTERN_MAX - 1)) begin
              hp_d = '0;
            end else begin
              hp_d = hp_q + swas_pkg::haddr_t'(1);
            end
            if (seen_q < swas_pkg::len_t'(swas_pkg::PATTERN_MAX)) begin
              seen_d = seen_q + swas_pkg::len_t'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      seen_q     <= '0;
      hp_q       <= '0;
      ovf_q      <= 1'b0;
      p1_valid_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      seen_q     <= seen_d;
      hp_q       <= hp_d;
      ovf_q      <= ovf_d;
      p1_valid_q <= accept;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    p1_kind_q <= kind;
    p1_clr_q  <= clr;
    p1_full_q <= full;
    p1_last_q <= s_axis_tlast;
    p1_ovf_q  <= ovf_d;
    p1_self_q <= (len_q == swas_pkg::len_t'(1));
    p1_sym_q  <= s_axis_tdata;
    p1_hp_q   <= hp_q;
    p1_old_q  <= old_addr;
  end

  // count entry at the byte, with forwarding of the previous item's write
  always_comb begin
    if (p2_awe_q && (p2_asym_q == p1_sym_q)) begin
      cnt_b = p2_adata_q;
    end else if (vld_a_q[p1_sym_q]) begin
      cnt_b = a_rdb_q;
    end else begin
      cnt_b = '0;
    end
    if (p2_rwe_q && (p2_rsym_q == p1_sym_q)) begin
      rem_b = p2_rdata_q;
    end else if (vld_r_q[p1_sym_q]) begin
      rem_b = r_rdb_q;
    end else begin
      rem_b = '0;
    end
    seen_new     = cnt_b.seen + swas_pkg::count_t'(1);
    wc_b         = seen_new - rem_b;
    inc_sat      = (cnt_b.pat != '0) && (wc_b == cnt_b.pat);
    hist_new.sym = p1_sym_q;
    hist_new.occ = seen_new;
    // leaving byte: this item itself, the previous item, or the ring
    if (p1_self_q) begin
      hist_d = hist_new;
    end else if (p2_hwe_q && (p2_hp_q == p1_old_q)) begin
      hist_d = p2_hdata_q;
    end else begin
      hist_d = h_rd_q;
    end
  end

  // stage 1 writes and distinct byte count
  always_comb begin
    a_we    = 1'b0;
    h_we    = 1'b0;
    r_we    = 1'b0;
    a_wdata = cnt_b;
    dn_d    = dn_q;
    vld_a_d = vld_a_q;
    vld_r_d = vld_r_q;
    if (p1_valid_q) begin
      unique case (p1_kind_q)
        swas_pkg::KIND_PAT: begin
          a_we = 1'b1;
          if (p1_clr_q) begin
            a_wdata.pat  = swas_pkg::count_t'(1);
            a_wdata.seen = '0;
            dn_d         = swas_pkg::dist_t'(1);
            vld_a_d      = '0;
            vld_r_d      = '0;
          end else begin
            a_wdata.pat = cnt_b.pat + swas_pkg::count_t'(1);
            if (cnt_b.pat == '0) begin
              dn_d = dn_q + swas_pkg::dist_t'(1);
            end
          end
          vld_a_d[p1_sym_q] = 1'b1;
        end
        swas_pkg::KIND_TEXT: begin
          a_we              = 1'b1;
          a_wdata.seen      = seen_new;
          vld_a_d[p1_sym_q] = 1'b1;
          h_we              = 1'b1;
          if (p1_full_q) begin
            r_we                = 1'b1;
            vld_r_d[hist_d.sym] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // count table: read at the new byte and at the leaving byte
  always_ff @(posedge clk_i) begin
    a_rdb_q <= cnt_mem[s_axis_tdata];
    a_rdd_q <= cnt_mem[hist_d.sym];
    if (a_we) begin
      cnt_mem[p1_sym_q] <= a_wdata;
    end
  end

  // removed-count table: occurrence number of the last byte that left
  always_ff @(posedge clk_i) begin
    r_rdb_q <= rem_mem[s_axis_tdata];
    if (r_we) begin
      rem_mem[hist_d.sym] <= hist_d.occ;
    end
  end

  // text history ring
  always_ff @(posedge clk_i) begin
    h_rd_q <= hist_mem[old_addr];
    if (h_we) begin
      hist_mem[p1_hp_q] <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q    <= '0;
      vld_r_q    <= '0;
      dn_q       <= '0;
      p2_valid_q <= 1'b0;
      p2_awe_q   <= 1'b0;
      p2_rwe_q   <= 1'b0;
      p2_hwe_q   <= 1'b0;
    end else begin
      vld_a_q    <= vld_a_d;
      vld_r_q    <= vld_r_d;
      dn_q       <= dn_d;
      p2_valid_q <= p1_valid_q;
      p2_awe_q   <= a_we;
      p2_rwe_q   <= r_we;
      p2_hwe_q   <= h_we;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk_i) begin
    p2_kind_q  <= p1_kind_q;
    p2_clr_q   <= p1_clr_q;
    p2_full_q  <= p1_full_q;
    p2_last_q  <= p1_last_q;
    p2_ovf_q   <= p1_ovf_q;
    p2_inc_q   <= inc_sat;
    p2_dsym_q  <= hist_d.sym;
    p2_occ_q   <= hist_d.occ;
    p2_asym_q  <= p1_sym_q;
    p2_adata_q <= a_wdata;
    p2_rsym_q  <= hist_d.sym;
    p2_rdata_q <= hist_d.occ;
    p2_hp_q    <= p1_hp_q;
    p2_hdata_q <= hist_new;
  end

  // leaving byte: window count and satisfied count, match decision
  always_comb begin
    if (p2_awe_q && (p2_asym_q == p2_dsym_q)) begin
      cnt_d = p2_adata_q;
    end else if (vld_a_q[p2_dsym_q]) begin
      cnt_d = a_rdd_q;
    end else begin
      cnt_d = '0;
    end
    wc_d    = cnt_d.seen - p2_occ_q + swas_pkg::count_t'(1);
    dec_sat = p2_full_q && (cnt_d.pat != '0) && (wc_d == cnt_d.pat);
    sat_inc = sat_q + swas_pkg::dist_t'(p2_inc_q);
    sat_d   = sat_q;
    found_d = found_q;
    res     = '0;
    if (p2_valid_q) begin
      unique case (p2_kind_q)
        swas_pkg::KIND_PAT: begin
          if (p2_clr_q) begin
            sat_d   = '0;
            found_d = 1'b0;
          end
        end
        swas_pkg::KIND_TEXT: begin
          sat_d            = sat_inc - swas_pkg::dist_t'(dec_sat);
          res.window_match = p2_full_q && (sat_inc == dn_q);
          if (res.window_match) begin
            found_d = 1'b1;
          end
          res.done_res = p2_last_q;
        end
        swas_pkg::KIND_EMPTY: begin
          res.window_match = 1'b1;
          found_d          = 1'b1;
          res.done_res     = p2_last_q;
        end
        default: ;
      endcase
    end
    res.found        = found_d;
    res.length_error = p2_ovf_q;
  end

  // result queue
  assign push = p2_valid_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q      <= '0;
      found_q    <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      sat_q   <= sat_d;
      found_q <= found_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + swas_pkg::optr_t'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + swas_pkg::optr_t'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + swas_pkg::ocnt_t'(push) - swas_pkg::ocnt_t'(pop);
    end
  end

  // output transaction
  assign out_res       = out_q[rd_ptr_q];
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = {5'b0, out_res.length_error, out_res.found, out_res.window_match};
  assign m_axis_tlast  = out_res.done_res;

`ifndef NO_ASSERTIONS
  // every accepted transaction reaches the result stage through the stage 1 and stage 2 registers
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 p2_valid_q)
    else $error("accepted transaction did not reach the result stage");

  // the admission check keeps the result queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fifo_cnt_q < swas_pkg::ocnt_t'(swas_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  // the leaving byte is still counted in the window
  a_leaving_byte_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q && (p2_kind_q == swas_pkg::KIND_TEXT) && p2_full_q |-> wc_d != '0)
    else $error("leaving byte has a zero window count");

  // satisfied bytes never outnumber distinct pattern bytes
  a_sat_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q && (p2_kind_q == swas_pkg::KIND_TEXT) |-> sat_inc <= dn_q)
    else $error("satisfied count exceeds distinct pattern bytes");

  // a text byte that uses the tables follows a non-empty pattern
  a_pattern_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q && (p2_kind_q == swas_pkg::KIND_TEXT) |-> dn_q != '0)
    else $error("text byte processed without pattern bytes");
`endif

endmodule
